[rtl/core/swbt_pkg.sv]
package swbt_pkg;

   // Queue between the request decoder and the pin sequencer.
   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNIT_TICKS      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_FACTOR     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONDITION_TICKS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DETECT_DELAY    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DETECT_LOW      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_TICKS    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHUTDOWN_TICKS  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ADDRESS  = 3'd7;

   localparam logic [7:0]  RST_UNIT_TICKS      = 8'd3;
   localparam logic [3:0]  RST_LONG_FACTOR     = 4'd3;
   localparam logic [7:0]  RST_CONDITION_TICKS = 8'd3;
   localparam logic [11:0] RST_DETECT_DELAY    = 12'd200;
   localparam logic [11:0] RST_DETECT_LOW      = 12'd300;
   localparam logic [11:0] RST_WINDOW_TICKS    = 12'd1000;
   localparam logic [15:0] RST_SHUTDOWN_TICKS  = 16'd3000;
   localparam logic [7:0]  RST_DEVICE_ADDRESS  = 8'h72;

   localparam logic [7:0] SKIP_ONCE_BRIGHTNESS = 8'd132;

   typedef enum logic [8:0] {
      PH_IDLE  = 9'b000000001,
      PH_SHUT  = 9'b000000010,
      PH_DHIGH = 9'b000000100,
      PH_DLOW  = 9'b000001000,
      PH_DREST = 9'b000010000,
      PH_START = 9'b000100000,
      PH_BLOW  = 9'b001000000,
      PH_BHIGH = 9'b010000000,
      PH_END   = 9'b100000000
   } phase_type;

   typedef enum logic {
      ITEM_TICK    = 1'b0,
      ITEM_REQUEST = 1'b1
   } item_kind_type;

   typedef struct packed {
      logic [7:0]  unit_ticks;
      logic [3:0]  long_factor;
      logic [7:0]  condition_ticks;
      logic [11:0] detect_delay_ticks;
      logic [11:0] detect_low_ticks;
      logic [11:0] window_ticks;
      logic [15:0] shutdown_ticks;
      logic [7:0]  device_address;
   } cfg_type;

   typedef struct packed {
      item_kind_type kind;
      logic [4:0]    level;
      logic          is_default;
   } item_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] countdown;
      logic [2:0]  bit_pos;
      logic        second_byte;
      logic        pin;
   } seq_state_type;

   // Enters a phase: sets the pin and loads the phase duration; entering idle keeps the pin.
   function automatic seq_state_type enter_phase(seq_state_type st, phase_type p,
                                                 logic [4:0] pending, cfg_type cfg);
      logic [11:0]   long_ticks;
      logic [12:0]   used;
      logic [12:0]   window_ext;
      logic [7:0]    byte_val;
      logic          bit_val;
      seq_state_type nx;
      long_ticks = 12'({4'd0, cfg.unit_ticks} * {8'd0, cfg.long_factor});
      used       = {1'b0, cfg.detect_delay_ticks} + {1'b0, cfg.detect_low_ticks};
      window_ext = {1'b0, cfg.window_ticks};
      byte_val   = st.second_byte ? {3'd0, pending} : cfg.device_address;
      bit_val    = byte_val[st.bit_pos];
      nx         = st;
      nx.phase   = p;
      unique case (p)
         PH_SHUT: begin
            nx.pin       = 1'b0;
            nx.countdown = cfg.shutdown_ticks;
         end
         PH_DHIGH: begin
            nx.pin       = 1'b1;
            nx.countdown = {4'd0, cfg.detect_delay_ticks};
         end
         PH_DLOW: begin
            nx.pin       = 1'b0;
            nx.countdown = {4'd0, cfg.detect_low_ticks};
         end
         PH_DREST: begin
            nx.pin       = 1'b1;
            nx.countdown = (window_ext > used) ? {3'd0, window_ext - used} : 16'd0;
         end
         PH_START: begin
            nx.pin       = 1'b1;
            nx.bit_pos   = 3'd7;
            nx.countdown = {8'd0, cfg.condition_ticks};
         end
         PH_BLOW: begin
            nx.pin       = 1'b0;
            nx.countdown = bit_val ? {8'd0, cfg.unit_ticks} : {4'd0, long_ticks};
         end
         PH_BHIGH: begin
            nx.pin       = 1'b1;
            nx.countdown = bit_val ? {4'd0, long_ticks} : {8'd0, cfg.unit_ticks};
         end
         PH_END: begin
            nx.pin       = 1'b0;
            nx.countdown = {8'd0, cfg.condition_ticks};
         end
         default: begin
            nx.phase     = PH_IDLE;
            nx.countdown = 16'd0;
         end
      endcase
      return nx;
   endfunction

   // Moves from a phase whose time has run out to the next one.
   function automatic seq_state_type advance_phase(seq_state_type st, logic [4:0] pending,
                                                   cfg_type cfg);
      seq_state_type nx;
      nx = st;
      unique case (st.phase)
         PH_SHUT:  nx = enter_phase(st, (pending != 5'd0) ? PH_DHIGH : PH_IDLE, pending, cfg);
         PH_DHIGH: nx = enter_phase(st, PH_DLOW, pending, cfg);
         PH_DLOW:  nx = enter_phase(st, PH_DREST, pending, cfg);
         PH_DREST: nx = enter_phase(st, PH_START, pending, cfg);
         PH_START: nx = enter_phase(st, PH_BLOW, pending, cfg);
         PH_BLOW:  nx = enter_phase(st, PH_BHIGH, pending, cfg);
         PH_BHIGH: begin
            if (st.bit_pos == 3'd0) begin
               nx = enter_phase(st, PH_END, pending, cfg);
            end else begin
               nx.bit_pos = st.bit_pos - 3'd1;
               nx = enter_phase(nx, PH_BLOW, pending, cfg);
            end
         end
         PH_END: begin
            nx.pin = 1'b1;
            if (!st.second_byte) begin
               nx.second_byte = 1'b1;
               nx = enter_phase(nx, PH_START, pending, cfg);
            end else begin
               nx.second_byte = 1'b0;
               nx = enter_phase(nx, PH_IDLE, pending, cfg);
            end
         end
         default: nx = enter_phase(st, PH_IDLE, pending, cfg);
      endcase
      return nx;
   endfunction

endpackage

[rtl/core/swbt_req_if.sv]
interface swbt_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] brightness;

   modport source (output valid, output mode, output brightness, input ready);
   modport sink   (input valid, input mode, input brightness, output ready);
endinterface

[rtl/core/swbt_rsp_if.sv]
interface swbt_rsp_if;
   logic valid;
   logic ready;
   logic pin_level;
   logic busy_res;
   logic dropped;

   modport source (output valid, output pin_level, output busy_res, output dropped,
                   input ready);
   modport sink   (input valid, input pin_level, input busy_res, input dropped,
                   output ready);
endinterface

[rtl/core/swbt_front.sv]
module swbt_front (
   swbt_req_if.sink           req_if,
   input  logic               queue_full,
   output logic               push_valid,
   output swbt_pkg::item_type push_item
);
   import swbt_pkg::*;

   // A transaction is taken whenever the queue has room; the sequencer state
   // decides later what a request actually does.
   assign req_if.ready = !queue_full;
   assign push_valid   = req_if.valid && !queue_full;

   always_comb begin
      push_item.kind       = req_if.mode ? ITEM_REQUEST : ITEM_TICK;
      push_item.level      = req_if.brightness[7:3];
      push_item.is_default = (req_if.brightness == SKIP_ONCE_BRIGHTNESS);
   end

endmodule

[rtl/core/swbt_queue.sv]
module swbt_queue #(
   parameter int unsigned DEPTH = swbt_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  swbt_pkg::item_type push_item,
   output logic               full,
   output logic               pop_valid,
   output swbt_pkg::item_type pop_item,
   input  logic               pop
);
   import swbt_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   item_type           entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entries_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/core/swbt_back.sv]
module swbt_back (
   input  logic               clock,
   input  logic               reset,
   input  swbt_pkg::cfg_type  cfg,
   input  logic               item_valid,
   input  swbt_pkg::item_type item,
   output logic               item_pop,
   swbt_rsp_if.source         rsp_if
);
   import swbt_pkg::*;

   seq_state_type seq_ff, seq_in;
   logic [4:0]    pending_ff, pending_in;
   logic [4:0]    last_level_ff, last_level_in;
   logic          last_valid_ff, last_valid_in;
   logic          initialized_ff, initialized_in;
   logic          default_seen_ff, default_seen_in;
   // Set while a transaction still has zero-length phases to skip.
   logic          active_ff, active_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_pin_ff, rsp_pin_in;
   logic          rsp_busy_ff, rsp_busy_in;
   logic          rsp_dropped_ff, rsp_dropped_in;

   logic          out_free;
   logic          stepped;
   logic          drop;
   logic          need_more;
   seq_state_type work;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign item_pop = !active_ff && item_valid && out_free;

   always_comb begin
      work            = seq_ff;
      pending_in      = pending_ff;
      last_level_in   = last_level_ff;
      last_valid_in   = last_valid_ff;
      initialized_in  = initialized_ff;
      default_seen_in = default_seen_ff;
      drop            = 1'b0;
      stepped         = 1'b0;

      if (active_ff) begin
         if (out_free) begin
            stepped = 1'b1;
            work    = advance_phase(seq_ff, pending_ff, cfg);
         end
      end else if (item_pop) begin
         stepped = 1'b1;
         unique case (item.kind)
            ITEM_TICK: begin
               if (seq_ff.phase != PH_IDLE) begin
                  if (seq_ff.countdown != 16'd0) begin
                     work.countdown = seq_ff.countdown - 16'd1;
                  end
                  if (work.countdown == 16'd0) begin
                     work = advance_phase(work, pending_ff, cfg);
                  end
               end
            end
            ITEM_REQUEST: begin
               if (seq_ff.phase != PH_IDLE) begin
                  drop = 1'b1;
               end else if (item.is_default && !default_seen_ff) begin
                  default_seen_in = 1'b1;
               end else if (!(last_valid_ff && (item.level == last_level_ff))) begin
                  last_level_in    = item.level;
                  last_valid_in    = 1'b1;
                  pending_in       = item.level;
                  work.second_byte = 1'b0;
                  if (item.level == 5'd0) begin
                     initialized_in = 1'b0;
                     work = enter_phase(work, PH_SHUT, item.level, cfg);
                  end else if (!initialized_ff) begin
                     initialized_in = 1'b1;
                     work = enter_phase(work, PH_SHUT, item.level, cfg);
                  end else begin
                     work = enter_phase(work, PH_START, item.level, cfg);
                  end
               end
            end
            default: ;
         endcase
      end

      seq_in    = work;
      need_more = (work.phase != PH_IDLE) && (work.countdown == 16'd0);
      active_in = stepped ? need_more : active_ff;

      rsp_pin_in     = rsp_pin_ff;
      rsp_busy_in    = rsp_busy_ff;
      rsp_dropped_in = rsp_dropped_ff;
      if (stepped && !need_more) begin
         rsp_valid_in   = 1'b1;
         rsp_pin_in     = work.pin;
         rsp_busy_in    = (work.phase != PH_IDLE);
         rsp_dropped_in = drop;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff.phase       <= PH_IDLE;
         seq_ff.countdown   <= 16'd0;
         seq_ff.bit_pos     <= 3'd7;
         seq_ff.second_byte <= 1'b0;
         seq_ff.pin         <= 1'b1;
         pending_ff         <= 5'd0;
         last_level_ff      <= 5'd0;
         last_valid_ff      <= 1'b0;
         initialized_ff     <= 1'b0;
         default_seen_ff    <= 1'b0;
         active_ff          <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         seq_ff             <= seq_in;
         pending_ff         <= pending_in;
         last_level_ff      <= last_level_in;
         last_valid_ff      <= last_valid_in;
         initialized_ff     <= initialized_in;
         default_seen_ff    <= default_seen_in;
         active_ff          <= active_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pin_ff     <= rsp_pin_in;
      rsp_busy_ff    <= rsp_busy_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.pin_level = rsp_pin_ff;
   assign rsp_if.busy_res  = rsp_busy_ff;
   assign rsp_if.dropped   = rsp_dropped_ff;

endmodule

[rtl/core/single_wire_backlight_transmitter_top.sv]
// Channel   Direction  Payload                        Handshake
// req_if    in         mode, brightness               valid / ready
// rsp_if    out        pin_level, busy_res, dropped   valid / ready
// csr_*     in         csr_index, csr_data            csr_write_en, no back-pressure
//
// One transaction per cycle is sustained while the output is free: each tick or request
// is one sequencer step, and each further zero-length phase holds new items for a step.
// Results appear in the output register in the cycle after the sequencer finishes.
// Reset is synchronous and restores the register defaults and an idle, high pin.
// A small queue separates input acceptance from the sequencer, so either side may stall.
module single_wire_backlight_transmitter_top #(
   parameter int unsigned QUEUE_DEPTH = swbt_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   swbt_req_if.sink                          req_if,
   swbt_rsp_if.source                        rsp_if,
   input  logic                              csr_write_en,
   input  logic [swbt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [swbt_pkg::CSR_DATA_W-1:0]   csr_data
);
   import swbt_pkg::*;

   cfg_type  cfg_ff;
   logic     queue_full;
   logic     push_valid;
   item_type push_item;
   logic     pop_valid;
   item_type pop_item;
   logic     pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unit_ticks         <= RST_UNIT_TICKS;
         cfg_ff.long_factor        <= RST_LONG_FACTOR;
         cfg_ff.condition_ticks    <= RST_CONDITION_TICKS;
         cfg_ff.detect_delay_ticks <= RST_DETECT_DELAY;
         cfg_ff.detect_low_ticks   <= RST_DETECT_LOW;
         cfg_ff.window_ticks       <= RST_WINDOW_TICKS;
         cfg_ff.shutdown_ticks     <= RST_SHUTDOWN_TICKS;
         cfg_ff.device_address     <= RST_DEVICE_ADDRESS;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_UNIT_TICKS:      cfg_ff.unit_ticks         <= csr_data[7:0];
            CSR_LONG_FACTOR:     cfg_ff.long_factor        <= csr_data[3:0];
            CSR_CONDITION_TICKS: cfg_ff.condition_ticks    <= csr_data[7:0];
            CSR_DETECT_DELAY:    cfg_ff.detect_delay_ticks <= csr_data[11:0];
            CSR_DETECT_LOW:      cfg_ff.detect_low_ticks   <= csr_data[11:0];
            CSR_WINDOW_TICKS:    cfg_ff.window_ticks       <= csr_data[11:0];
            CSR_SHUTDOWN_TICKS:  cfg_ff.shutdown_ticks     <= csr_data;
            CSR_DEVICE_ADDRESS:  cfg_ff.device_address     <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   swbt_front u_front (
      .req_if     (req_if),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   swbt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop        (pop)
   );

   swbt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (pop_valid),
      .item       (pop_item),
      .item_pop   (pop),
      .rsp_if     (rsp_if)
   );

endmodule
